### sv/apa_pkg.sv
// Shared types and constants for the average plaquette accumulator.
// No dependencies; imported by every module of the block.
package apa_pkg;

  localparam int MAX_SITES_DEF  = 65536;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int LINK_W  = 16;
  localparam int COS_W   = 18;  // signed Q1.16 cosine, -65536..65536
  localparam int SUM_W   = 35;  // signed accumulator
  localparam int MAG_W   = 34;  // magnitude of the accumulator
  localparam int COUNT_W = 18;  // plaquette count register
  localparam int MEAN_W  = 18;  // signed Q1.16 mean

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(3);
  localparam logic [16:0]        ONE_Q16     = 17'd65536;

  // Cosine lane pipeline depth: phase, square, five Horner products, finish.
  localparam int LANE_LAT = 8;

  // Q30 Horner coefficients of cos(pi/2 * u), lowest order first.
  localparam int COEF_W = 31;
  localparam logic [COEF_W-1:0] COS_COEF [0:4] = '{
    31'd1324675879, 31'd272375560, 31'd22401992, 31'd987048, 31'd27061
  };

  // Per-beat control that rides along with the lanes.
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  // Handoff from the accumulator to the divider.
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
  } div_req_t;

endpackage

### sv/apa_cos_lane.sv
// One plaquette cosine lane: angle sum, quadrant fold, Horner polynomial.
// Depends on apa_pkg (coefficients, widths).
module apa_cos_lane import apa_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic [LINK_W-1:0]       a,
  input  logic [LINK_W-1:0]       b,
  input  logic [LINK_W-1:0]       c,
  input  logic [LINK_W-1:0]       d,
  output logic signed [COS_W-1:0] cos_q16
);

  logic [31:0]           sum32;
  logic [ANGLE_BITS-1:0] angle;
  logic [15:0]           phase;
  logic [1:0]            quad;
  logic [14:0]           u_next;

  assign sum32 = {16'b0, a} + {16'b0, b} - {16'b0, c} - {16'b0, d};
  assign angle = sum32[ANGLE_BITS-1:0];

  generate
    if (ANGLE_BITS >= 16) begin : g_trunc
      assign phase = angle[ANGLE_BITS-1 -: 16];
    end else begin : g_pad
      localparam int SHIFT_UP = 16 - ANGLE_BITS;
      assign phase = 16'(angle) << SHIFT_UP;
    end
  endgenerate

  assign quad   = phase[15:14];
  assign u_next = quad[0] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};

  // stage A: folded phase
  logic [14:0] u;
  logic        neg_q [0:6];
  // stage B: z = u*u (Q28, at most 2^28)
  logic [29:0] zprod;
  logic [28:0] z_q [0:4];
  // stages C..G: Horner products
  logic [59:0] prod [0:4];
  // Horner partial terms between the product stages
  logic [31:0]       diff [1:4];
  logic [COEF_W-1:0] h    [1:4];

  assign zprod = 30'(u) * 30'(u);

  always_comb begin
    for (int i = 1; i < 5; i++) begin
      diff[i] = {1'b0, COS_COEF[4-i]} - prod[i-1][59:28];
      h[i]    = diff[i][COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    u        <= u_next;
    neg_q[0] <= quad[1] ^ quad[0];
    z_q[0]   <= zprod[28:0];
    prod[0]  <= COS_COEF[4] * z_q[0];
    for (int i = 1; i < 7; i++) neg_q[i] <= neg_q[i-1];
    for (int i = 1; i < 5; i++) z_q[i] <= z_q[i-1];
    for (int i = 1; i < 5; i++) prod[i] <= h[i] * z_q[i];
  end

  // stage H: 1 - t*z, clamp, round half up to Q16, cap, sign
  logic signed [33:0] v;
  logic [33:0]        v_pos;
  logic [33:0]        v_rnd;
  logic [16:0]        mag;

  assign v     = 34'sd1073741824 - $signed({2'b0, prod[4][59:28]});
  assign v_pos = v[33] ? 34'd0 : 34'(v);
  assign v_rnd = v_pos + 34'd8192;
  assign mag   = (v_rnd[33:14] > 20'(ONE_Q16)) ? ONE_Q16 : v_rnd[30:14];

  always_ff @(posedge clk) begin
    cos_q16 <= neg_q[6] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

### sv/apa_accum.sv
// Merge stage: adds the three lane cosines into the saturating accumulator.
// Depends on apa_pkg (ctl_t, div_req_t, widths).
module apa_accum import apa_pkg::*; #(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctl_t                    ctl,
  input  logic signed [COS_W-1:0] cos_xy,
  input  logic signed [COS_W-1:0] cos_xt,
  input  logic signed [COS_W-1:0] cos_yt,
  output div_req_t                req
);

  localparam longint SITE_LIM = longint'(MAX_SITES) * 64'sd196608;
  localparam longint HARD_LIM = 64'sd17179869183;
  localparam longint ACC_LIM  = (SITE_LIM < HARD_LIM) ? SITE_LIM : HARD_LIM;
  localparam logic signed [SUM_W:0] LIM_POS = (SUM_W+1)'(ACC_LIM);
  localparam logic signed [SUM_W:0] LIM_NEG = -LIM_POS;

  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W:0]   total;
  logic signed [SUM_W-1:0] sat;

  assign total = (SUM_W+1)'(acc) + (SUM_W+1)'(cos_xy) + (SUM_W+1)'(cos_xt)
               + (SUM_W+1)'(cos_yt);

  always_comb begin
    if (total > LIM_POS) begin
      sat = SUM_W'(LIM_POS);
    end else if (total < LIM_NEG) begin
      sat = SUM_W'(LIM_NEG);
    end else begin
      sat = total[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      req.start <= 1'b0;
    end else begin
      req.start <= ctl.valid && ctl.last;
      if (ctl.valid) begin
        acc <= ctl.last ? '0 : sat;
      end
      if (ctl.valid && ctl.last) begin
        req.sum <= sat;
      end
    end
  end

endmodule

### sv/apa_divider.sv
// Restoring divider for the mean, one quotient bit per cycle, plus result hold.
// Depends on apa_pkg (div_req_t, widths).
module apa_divider import apa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  div_req_t                 req,
  input  logic [COUNT_W-1:0]       count,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MEAN_W-1:0] mean,
  output logic signed [SUM_W-1:0]  sum
);

  typedef enum logic [1:0] {IDLE, RUN, HOLD} state_t;

  localparam int CNT_W = $clog2(MAG_W + 1);

  state_t             state;
  logic               neg;
  logic [COUNT_W-1:0] divisor;
  logic [COUNT_W-1:0] rem;
  logic [MAG_W-1:0]   quo;
  logic [CNT_W-1:0]   steps;

  logic [COUNT_W:0]   trial;
  logic               fits;
  logic [COUNT_W:0]   diff;
  logic [MAG_W-1:0]   quo_next;
  logic [16:0]        qcap;
  logic [SUM_W-1:0]   abs_sum;

  assign trial    = {rem, quo[MAG_W-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign diff     = trial - {1'b0, divisor};
  assign quo_next = {quo[MAG_W-2:0], fits};
  assign qcap     = (quo_next > MAG_W'(ONE_Q16)) ? ONE_Q16 : quo_next[16:0];
  assign abs_sum  = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);

  assign busy      = state != IDLE;
  assign out_valid = state == HOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      steps <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (req.start) begin
            state   <= RUN;
            steps   <= '0;
            neg     <= req.sum[SUM_W-1];
            sum     <= req.sum;
            quo     <= abs_sum[MAG_W-1:0];
            rem     <= '0;
            divisor <= (count == '0) ? COUNT_W'(1) : count;
          end
        end
        RUN: begin
          rem   <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
          quo   <= quo_next;
          steps <= steps + CNT_W'(1);
          if (steps == CNT_W'(MAG_W - 1)) begin
            state <= HOLD;
            mean  <= neg ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});
          end
        end
        HOLD: begin
          if (out_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### sv/average_plaquette_accumulator.sv
// Average plaquette accumulator for a U(1) gauge field on an x-y-t lattice.
// Throughput: one site beat per cycle while s_tready is high; three cosine
// lanes feed one adder. A beat passes the lane stages and the accumulator
// register; the result beat of a sweep follows once the divider has run.
// A last-site beat is held off until the previous result beat is taken.
// Reset (rst, synchronous): accumulator 0, plaquette_count 3, no result pending.
module average_plaquette_accumulator import apa_pkg::*; #(
  parameter int MAX_SITES  = MAX_SITES_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // site stream
  input  logic               s_tvalid,
  output logic               s_tready,
  // link_x, link_y, link_t, link_y_next_x, link_t_next_x,
  // link_x_next_y, link_t_next_y, link_x_next_t, link_y_next_t (16 bits each)
  input  logic [143:0]       s_tdata,
  input  logic               s_tlast,   // last_site
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  // average_plaquette [17:0], plaquette_sum [52:18], zero pad [55:53]
  output logic [55:0]        m_tdata,
  // plaquette_count register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [LINK_W-1:0] lx, ly, lt, y_nx, t_nx, x_ny, t_ny, x_nt, y_nt;

  assign lx   = s_tdata[15:0];
  assign ly   = s_tdata[31:16];
  assign lt   = s_tdata[47:32];
  assign y_nx = s_tdata[63:48];
  assign t_nx = s_tdata[79:64];
  assign x_ny = s_tdata[95:80];
  assign t_ny = s_tdata[111:96];
  assign x_nt = s_tdata[127:112];
  assign y_nt = s_tdata[143:128];

  // config register; writes must come only while idle, the block does not enforce it
  logic [COUNT_W-1:0] plaquette_count;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plaquette_count <= COUNT_RESET;
    end else if (cfg_valid) begin
      plaquette_count <= cfg_data;
    end
  end

  // control shift line, aligned with the lane stages
  ctl_t ctl_q [0:LANE_LAT-1];
  logic last_in_flight;
  logic div_busy;
  div_req_t req;

  always_comb begin
    last_in_flight = 1'b0;
    for (int i = 0; i < LANE_LAT; i++) begin
      last_in_flight = last_in_flight | (ctl_q[i].valid & ctl_q[i].last);
    end
  end

  // Plain sites always flow; a last site waits for the divider and output.
  assign s_tready = !(s_tlast && (last_in_flight || req.start || div_busy));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0].valid <= s_tvalid && s_tready;
      ctl_q[0].last  <= s_tlast;
      for (int i = 1; i < LANE_LAT; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  // three plaquette lanes
  logic signed [COS_W-1:0] cos_xy, cos_xt, cos_yt;

  apa_cos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_xy (
    .clk(clk), .a(lx), .b(y_nx), .c(x_ny), .d(ly), .cos_q16(cos_xy)
  );
  apa_cos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_xt (
    .clk(clk), .a(lx), .b(t_nx), .c(x_nt), .d(lt), .cos_q16(cos_xt)
  );
  apa_cos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_yt (
    .clk(clk), .a(ly), .b(t_ny), .c(y_nt), .d(lt), .cos_q16(cos_yt)
  );

  // merge stage
  apa_accum #(.MAX_SITES(MAX_SITES)) u_accum (
    .clk(clk), .rst(rst), .ctl(ctl_q[LANE_LAT-1]),
    .cos_xy(cos_xy), .cos_xt(cos_xt), .cos_yt(cos_yt), .req(req)
  );

  // mean and result hold
  logic signed [MEAN_W-1:0] mean;
  logic signed [SUM_W-1:0]  sum;

  apa_divider u_div (
    .clk(clk), .rst(rst), .req(req), .count(plaquette_count),
    .busy(div_busy), .out_valid(m_tvalid), .out_ready(m_tready),
    .mean(mean), .sum(sum)
  );

  assign m_tdata = {3'b000, sum, mean};

endmodule

### tb/plaquette_checker.sv
`timescale 1ns / 100ps
// Result checker for average_plaquette_accumulator: predicts each sweep result
// from the accepted site beats and compares it with the result beats.
// Depends on apa_pkg for channel widths.
module plaquette_checker import apa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [143:0]       s_tdata,
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [55:0]        m_tdata,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  output int                 mismatch_count,
  output int                 results_pending
);

  // Q30 Horner coefficients of cos(pi/2 * u), u in Q14
  localparam longint unsigned COS_C1 = 64'd1324675879;
  localparam longint unsigned COS_C2 = 64'd272375560;
  localparam longint unsigned COS_C3 = 64'd22401992;
  localparam longint unsigned COS_C4 = 64'd987048;
  localparam longint unsigned COS_C5 = 64'd27061;
  localparam longint          ONE_Q16_L = 64'sd65536;
  // min(MAX_SITES * 196608, 2^34 - 1)
  localparam longint          SUM_LIMIT = 64'sd12884901888;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic signed [SUM_W-1:0]  sum;
  } sweep_result_t;

  sweep_result_t     sweep_results_q[$];
  logic [COUNT_W-1:0] plaq_count;
  longint            cos_sum;
  int                errors = 0;

  logic [15:0] lx, ly, lt, y_nx, t_nx, x_ny, t_ny, x_nt, y_nt;
  assign {y_nt, x_nt, t_ny, x_ny, t_nx, y_nx, lt, ly, lx} = s_tdata;

  function automatic longint quarter_wave_cos(input longint unsigned u);
    longint unsigned z, h;
    longint          v;
    z = u * u;
    h = COS_C5;
    h = COS_C4 - ((h * z) >> 28);
    h = COS_C3 - ((h * z) >> 28);
    h = COS_C2 - ((h * z) >> 28);
    h = COS_C1 - ((h * z) >> 28);
    v = longint'(64'd1 << 30) - longint'((h * z) >> 28);
    if (v < 0) v = 0;
    v = (v + 8192) / 16384;
    if (v > ONE_Q16_L) v = ONE_Q16_L;
    return v;
  endfunction

  // cosine of the plaquette angle a + b - c - d, one turn = 2^16
  function automatic longint plaquette_cos(input logic [15:0] a, b, c, d);
    logic [15:0]     phase;
    longint unsigned folded;
    longint          mag;
    phase  = a + b - c - d;
    folded = phase[14] ? 64'd16384 - phase[13:0] : 64'(phase[13:0]);
    mag    = quarter_wave_cos(folded);
    // second and third quadrant are negative
    return (phase[15] ^ phase[14]) ? -mag : mag;
  endfunction

  always @(posedge clk) begin : watch
    sweep_result_t   want;
    logic signed [MEAN_W-1:0] got_mean;
    logic signed [SUM_W-1:0]  got_sum;
    longint unsigned mag, quot, divisor;
    if (rst) begin
      sweep_results_q.delete();
      plaq_count = COUNT_W'(3);
      cos_sum    = 0;
    end else begin
      if (cfg_valid && cfg_ready) plaq_count = cfg_data;

      if (s_tvalid && s_tready) begin
        cos_sum += plaquette_cos(lx, y_nx, x_ny, ly);
        cos_sum += plaquette_cos(lx, t_nx, x_nt, lt);
        cos_sum += plaquette_cos(ly, t_ny, y_nt, lt);
        if (cos_sum > SUM_LIMIT) cos_sum = SUM_LIMIT;
        if (cos_sum < -SUM_LIMIT) cos_sum = -SUM_LIMIT;
        if (s_tlast) begin
          // zero count divides by one; mean truncates toward zero
          divisor = (plaq_count == 0) ? 64'd1 : 64'(plaq_count);
          mag     = (cos_sum < 0) ? longint'(-cos_sum) : longint'(cos_sum);
          quot    = mag / divisor;
          if (quot > 64'd65536) quot = 64'd65536;
          want.mean = (cos_sum < 0) ? MEAN_W'(-longint'(quot)) : MEAN_W'(quot);
          want.sum  = SUM_W'(cos_sum);
          sweep_results_q.push_back(want);
          cos_sum = 0;
        end
      end

      if (m_tvalid && m_tready) begin
        got_mean = m_tdata[17:0];
        got_sum  = m_tdata[52:18];
        if (sweep_results_q.size() == 0) begin
          if (errors < 10)
            $display("%0t chk: result beat with none expected: mean %0d sum %0d",
                     $realtime, got_mean, got_sum);
          errors++;
        end else begin
          want = sweep_results_q.pop_front();
          if (got_mean !== want.mean || got_sum !== want.sum) begin
            if (errors < 10)
              $display("%0t chk: mismatch: mean exp %0d got %0d, sum exp %0d got %0d",
                       $realtime, want.mean, got_mean, want.sum, got_sum);
            errors++;
          end
        end
      end
    end
    mismatch_count  <= errors;
    results_pending <= sweep_results_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the average_plaquette_accumulator testbench: clock, reset, site and
// register stimulus, result-side back-pressure and the verdict.
// Depends on apa_pkg, the block and plaquette_checker.
module tb_top;
  import apa_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int DRAIN_CYCLES  = 60;      // longer than the block latency
  localparam int HOLD_CYCLES   = 400;     // long result-side hold-off
  localparam int ALIGNED_SITES = 16;
  localparam int PHASE_SITES   = 225;

  // plaquette angle targets, fractions of a turn
  localparam logic [15:0] ANG_ZERO    = 16'h0000;
  localparam logic [15:0] ANG_QUARTER = 16'h4000;
  localparam logic [15:0] ANG_HALF    = 16'h8000;
  localparam logic [15:0] ANG_3QUART  = 16'hC000;

  typedef struct packed {
    logic [15:0] y_nt, x_nt, t_ny, x_ny, t_nx, y_nx, lt, ly, lx;
  } site_links_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [143:0]       s_tdata = '0;  // lx, ly, lt, y_nx, t_nx, x_ny, t_ny, x_nt, y_nt
  logic               s_tlast = 1'b0;  // last_site
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [55:0]        m_tdata;       // average_plaquette, plaquette_sum, pad
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  int  mismatch_count;
  int  results_pending;
  int  idle_pct  = 0;   // chance per beat that the sender idles
  int  stall_pct = 0;   // chance per cycle that the receiver stalls
  int  hold_reqs  = 0;  // hold-offs asked for by the stimulus
  int  holds_seen = 0;  // hold-offs started by the result side
  int  hold_left = 0;
  int  cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  average_plaquette_accumulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  plaquette_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Watchdog: a correct run ends far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side. A hold request starts a long stretch with tready low; the
  // sender keeps going meanwhile so the block backs up into its input.
  always @(posedge clk) begin
    if (hold_reqs != holds_seen) begin
      holds_seen <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Random links, with the last link of each plaquette solved so the three
  // plaquette angles land on the given targets.
  function automatic site_links_t aimed_site(input logic [15:0] t_xy, t_xt, t_yt);
    site_links_t s;
    s      = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
    s.x_ny = s.lx + s.y_nx - s.ly - t_xy;
    s.x_nt = s.lx + s.t_nx - s.lt - t_xt;
    s.y_nt = s.ly + s.t_ny - s.lt - t_yt;
    return s;
  endfunction

  // near a quadrant boundary, within two steps either way
  function automatic logic [15:0] edge_angle();
    logic [15:0] a;
    a = {2'($urandom_range(3)), 14'd0};
    return a + 16'($urandom_range(4)) - 16'd2;
  endfunction

  task automatic send_site(input site_links_t s, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Block is idle once every result is back and the pipeline has drained.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly random sweeps; a quarter of the sites sit near quadrant edges.
  task automatic random_sweeps(input int n_sites, input int idle, input int stall,
                               input bit with_hold);
    site_links_t s;
    logic        last;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n_sites; i++) begin
      if (with_hold && i == n_sites / 3) hold_reqs <= hold_reqs + 1;
      if ($urandom_range(3) == 0)
        s = aimed_site(edge_angle(), edge_angle(), edge_angle());
      else
        s = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
      last = ($urandom_range(7) == 0) || (i == n_sites - 1);
      send_site(s, last);
    end
    wait_idle();
  endtask

  function automatic logic [COUNT_W-1:0] random_count();
    if ($urandom_range(1))
      return COUNT_W'($urandom_range(12, 1));
    return COUNT_W'($urandom_range(196608, 1));
  endfunction

  initial begin
    site_links_t s;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset divisor of 3: full-scale sums both ways, quadrant edges, extremes
    send_site(aimed_site(ANG_ZERO, ANG_ZERO, ANG_ZERO), 1'b1);
    send_site(aimed_site(ANG_HALF, ANG_HALF, ANG_HALF), 1'b1);
    send_site(aimed_site(ANG_QUARTER, ANG_3QUART, 16'h2000), 1'b0);
    send_site(aimed_site(16'h3FFF, 16'h4001, 16'hBFFF), 1'b0);
    send_site(aimed_site(16'hC001, 16'h7FFF, 16'h8001), 1'b0);
    send_site(aimed_site(16'hFFFF, 16'h0001, 16'h6000), 1'b1);
    s = '1;
    send_site(s, 1'b0);
    s = '0;
    s.lx = 16'hFFFF;
    send_site(s, 1'b1);
    wait_idle();

    // divisor 1: the mean clamps at plus and minus one
    write_count(COUNT_W'(1));
    send_site(aimed_site(ANG_ZERO, ANG_ZERO, ANG_ZERO), 1'b0);
    send_site(aimed_site(ANG_ZERO, ANG_ZERO, ANG_ZERO), 1'b1);
    send_site(aimed_site(ANG_HALF, ANG_HALF, ANG_HALF), 1'b0);
    send_site(aimed_site(ANG_HALF, ANG_HALF, ANG_HALF), 1'b1);
    send_site(aimed_site(16'h1000, 16'h9000, 16'h5000), 1'b1);
    wait_idle();

    // zero divisor is taken as one
    write_count(COUNT_W'(0));
    send_site(aimed_site(16'h2000, ANG_ZERO, 16'h2000), 1'b1);
    wait_idle();

    // largest nominal count: aligned sweeps of both signs
    write_count(COUNT_W'(196608));
    for (int i = 0; i < ALIGNED_SITES; i++)
      send_site(aimed_site(ANG_ZERO, ANG_ZERO, ANG_ZERO), i == ALIGNED_SITES - 1);
    for (int i = 0; i < ALIGNED_SITES; i++)
      send_site(aimed_site(ANG_HALF, ANG_HALF, ANG_HALF), i == ALIGNED_SITES - 1);
    wait_idle();

    // largest count the register holds
    write_count('1);
    send_site(aimed_site(ANG_ZERO, ANG_ZERO, ANG_ZERO), 1'b0);
    send_site(aimed_site(ANG_3QUART, ANG_QUARTER, ANG_ZERO), 1'b1);
    wait_idle();

    // random part, one divisor per phase
    write_count(random_count());
    random_sweeps(PHASE_SITES, 0, 0, 1'b1);
    write_count(random_count());
    random_sweeps(PHASE_SITES, 78, 0, 1'b0);
    write_count(random_count());
    random_sweeps(PHASE_SITES, 0, 78, 1'b0);
    write_count(random_count());
    random_sweeps(PHASE_SITES, 29, 29, 1'b0);

    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
